### hw/rtl/tcfc_pkg.sv
// Timecode frame converter package: payload structs, divider interface,
// sequencer states, command and register codes, small arithmetic helpers.
// No dependencies.
package tcfc_pkg;

  // Field and datapath widths
  localparam int FieldW   = 7;
  localparam int CountW   = 23;
  localparam int FpsW     = 6;
  localparam int DivW     = 23;
  localparam int QbW      = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;

  localparam logic [QbW-1:0] DivWCount = QbW'(DivW);

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgRateWhole = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDropMode  = 1'b1;

  // Command codes
  localparam logic [1:0] CmdTcToCount = 2'd0;
  localparam logic [1:0] CmdCountToTc = 2'd1;
  localparam logic [1:0] CmdAddOffset = 2'd2;
  localparam logic [1:0] CmdSubOffset = 2'd3;

  // Quotient bit counts per division (bounded by the value ranges)
  localparam logic [QbW-1:0] QbVal   = 5'd7;   // frame_value / day length
  localparam logic [QbW-1:0] QbFmod  = 5'd7;   // input frames / fps
  localparam logic [QbW-1:0] QbBlock = 5'd9;   // count / ten-minute block
  localparam logic [QbW-1:0] QbMin   = 5'd5;   // block remainder / drop minute
  localparam logic [QbW-1:0] QbFps   = 5'd17;  // label frames / fps
  localparam logic [QbW-1:0] QbSec   = 5'd11;  // seconds / 60
  localparam logic [QbW-1:0] QbHrs   = 5'd5;   // minutes / 60

  typedef struct packed {
    logic [1:0]        command;
    logic [FieldW-1:0] in_hours;
    logic [FieldW-1:0] in_minutes;
    logic [FieldW-1:0] in_seconds;
    logic [FieldW-1:0] in_frames;
    logic [CountW-1:0] frame_value;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        out_hours;
    logic [5:0]        out_minutes;
    logic [5:0]        out_seconds;
    logic [5:0]        out_frames;
    logic [CountW-1:0] frame_count;
  } out_item_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
    logic [QbW-1:0]  qbits;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quotient;
    logic [DivW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VAL,
    ST_FMOD,
    ST_NORM_S,
    ST_NORM_MH,
    ST_LBL_A,
    ST_LBL_B,
    ST_COMBINE,
    ST_BLOCK,
    ST_DROP_ADJ,
    ST_MIN,
    ST_FPS,
    ST_SEC,
    ST_HRS,
    ST_FINISH
  } state_t;

  // Nominal rate: 0 means 24, 23/29/59 round up
  function automatic logic [FpsW-1:0] rate_to_fps(input logic [FpsW-1:0] rate);
    logic [FpsW-1:0] r;
    r = rate;
    if (r == 6'd0) r = 6'd24;
    if (r == 6'd23 || r == 6'd29 || r == 6'd59) r = r + 6'd1;
    return r;
  endfunction

  // x mod 60 for x below 180
  function automatic logic [5:0] mod60_u8(input logic [7:0] x);
    logic [7:0] v;
    v = x;
    if (v >= 8'd120) v = v - 8'd120;
    if (v >= 8'd60) v = v - 8'd60;
    return v[5:0];
  endfunction

  // x mod 24 for x below 192
  function automatic logic [4:0] mod24_u8(input logic [7:0] x);
    logic [7:0] v;
    v = x;
    if (v >= 8'd96) v = v - 8'd96;
    if (v >= 8'd48) v = v - 8'd48;
    if (v >= 8'd24) v = v - 8'd24;
    return v[4:0];
  endfunction

  // x / 10 by reciprocal, exact for every 11-bit x
  function automatic logic [7:0] div10_u11(input logic [10:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd6554;
    return p[23:16];
  endfunction

endpackage

### hw/rtl/tcfc_div.sv
// Shared restoring divider: one quotient bit per cycle, bit count per request.
// Depends on tcfc_pkg (div_req_t, div_rsp_t, widths).
module tcfc_div (
  input  logic                clk,
  input  logic                rst,
  input  tcfc_pkg::div_req_t  req,
  output tcfc_pkg::div_rsp_t  rsp
);

  logic                         busy;
  logic                         done;
  logic [tcfc_pkg::QbW-1:0]     cnt;
  logic [tcfc_pkg::DivW-1:0]    rem;
  logic [tcfc_pkg::DivW-1:0]    low;
  logic [tcfc_pkg::DivW-1:0]    quo;
  logic [tcfc_pkg::DivW:0]      trial;
  logic [tcfc_pkg::DivW:0]      trial_sub;
  logic                         ge;

  // One step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial     = {rem, low[tcfc_pkg::DivW-1]};
    trial_sub = trial - {1'b0, req.divisor};
    ge        = trial >= {1'b0, req.divisor};
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.qbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the upper part of the dividend is known to be below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.dividend >> req.qbits;
      low <= req.dividend << (tcfc_pkg::DivWCount - req.qbits);
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? trial_sub[tcfc_pkg::DivW-1:0] : trial[tcfc_pkg::DivW-1:0];
      low <= {low[tcfc_pkg::DivW-2:0], 1'b0};
      quo <= {quo[tcfc_pkg::DivW-2:0], ge};
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("divider started while busy");
  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy) else $error("divider did not start");
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("divider done while still stepping");

endmodule

### hw/rtl/timecode_frame_converter.sv
// Timecode frame converter top level: sequencer, label arithmetic, result register.
// Depends on tcfc_pkg and tcfc_div.
//
//   channel  | signals                          | direction | handshake
//   ---------+----------------------------------+-----------+-----------------
//   cmd      | cmd_valid cmd_ready cmd_data     | in        | valid/ready
//   res      | res_valid res_ready res_data     | out       | valid/ready
//   cfg      | cfg_we cfg_index cfg_data        | in        | write enable
//
// One transaction at a time; cmd_ready is high only while the sequencer is idle.
// Accept to result runs through the shared divider, one division at a time
// (up to seven), each stepping once per quotient bit.
// Count to timecode is quickest; add/subtract with drop-frame takes the longest.
// The result register frees the sequencer: a new command is accepted while a
// result waits; the sequencer only waits at the end if the old one is not taken.
// Reset (synchronous) sets 24 fps, non-drop, idle, no result pending.
module timecode_frame_converter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tcfc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tcfc_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  tcfc_pkg::in_item_t                cmd_data,
  output logic                              res_valid,
  input  logic                              res_ready,
  output tcfc_pkg::out_item_t               res_data
);

  // Configuration registers
  logic [5:0] rate_whole;
  logic       drop_mode;

  // Rate-derived constants, refreshed every cycle
  logic [5:0]  fps_c;
  logic [2:0]  d_c;
  logic [5:0]  fps_q;
  logic [2:0]  d_q;
  logic [5:0]  d9_q;
  logic [22:0] day_q;
  logic [15:0] block_q;
  logic [11:0] minute_q;

  // Sequencer
  tcfc_pkg::state_t state, state_next;
  logic             launched;
  logic             is_div_state;
  tcfc_pkg::div_req_t div_req;
  tcfc_pkg::div_rsp_t div_rsp;

  // Item and working registers
  tcfc_pkg::in_item_t item_r;
  logic [22:0] val_mod;
  logic [22:0] count_r;
  logic [22:0] raw_r;
  logic [5:0]  f_n;
  logic        fcarry;
  logic [5:0]  s_n;
  logic [7:0]  m1_r;
  logic [5:0]  m_n;
  logic [4:0]  h_n;
  logic [16:0] secs_lbl;
  logic [5:0]  fadj;
  logic [12:0] dsub;
  logic [22:0] t_r;
  logic [8:0]  q_blk;
  logic [15:0] r_blk;
  logic [15:0] rr_r;
  logic [16:0] secs_r;
  logic [10:0] mins_r;
  logic [4:0]  hr_o;
  logic [5:0]  min_o;
  logic [5:0]  sec_o;
  logic [5:0]  fr_o;
  logic        out_free;

  // Combinational helpers for the label steps
  logic [7:0]  s1;
  logic        scarry;
  logic [7:0]  m1_c;
  logic        mcarry;
  logic [7:0]  h1;
  logic [10:0] tm;
  logic [7:0]  tm10;
  logic [7:0]  mq;
  logic        mrem_nz;
  logic        drop_label;
  logic [5:0]  fadj_c;
  logic [12:0] dsub_c;
  logic [16:0] secs_lbl_c;
  logic [22:0] t_c;
  logic [23:0] sum;
  logic [23:0] sum_w;
  logic [23:0] diff;
  logic [23:0] diff_w;
  logic [22:0] count_c;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_whole <= 6'd24;
      drop_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcfc_pkg::CfgRateWhole: rate_whole <= cfg_data[5:0];
        tcfc_pkg::CfgDropMode:  drop_mode  <= cfg_data[0];
      endcase
    end
  end

  // Nominal rate and drop count (zero when not dropping)
  always_comb begin
    fps_c = tcfc_pkg::rate_to_fps(rate_whole);
    if (drop_mode && (fps_c == 6'd30 || fps_c == 6'd60)) begin
      d_c = (fps_c == 6'd60) ? 3'd4 : 3'd2;
    end else begin
      d_c = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    fps_q    <= fps_c;
    d_q      <= d_c;
    d9_q     <= 6'(d_c) * 6'd9;
    day_q    <= 23'(fps_c) * 23'd86400 - 23'(d_c) * 23'd1296;
    block_q  <= 16'(fps_c) * 16'd600 - 16'(d_c) * 16'd9;
    minute_q <= 12'(fps_c) * 12'd60 - 12'(d_c);
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcfc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider launch tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      launched <= 1'b0;
    end else if (div_rsp.done) begin
      launched <= 1'b0;
    end else if (div_req.start) begin
      launched <= 1'b1;
    end
  end

  assign out_free = !res_valid || res_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tcfc_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd_data.command == tcfc_pkg::CmdTcToCount) ?
                       tcfc_pkg::ST_FMOD : tcfc_pkg::ST_VAL;
        end
      end
      tcfc_pkg::ST_VAL: begin
        if (div_rsp.done) begin
          if (item_r.command != tcfc_pkg::CmdCountToTc) begin
            state_next = tcfc_pkg::ST_FMOD;
          end else begin
            state_next = (d_q != 3'd0) ? tcfc_pkg::ST_BLOCK : tcfc_pkg::ST_FPS;
          end
        end
      end
      tcfc_pkg::ST_FMOD: begin
        if (div_rsp.done) state_next = tcfc_pkg::ST_NORM_S;
      end
      tcfc_pkg::ST_NORM_S:  state_next = tcfc_pkg::ST_NORM_MH;
      tcfc_pkg::ST_NORM_MH: state_next = tcfc_pkg::ST_LBL_A;
      tcfc_pkg::ST_LBL_A:   state_next = tcfc_pkg::ST_LBL_B;
      tcfc_pkg::ST_LBL_B:   state_next = tcfc_pkg::ST_COMBINE;
      tcfc_pkg::ST_COMBINE: begin
        state_next = (d_q != 3'd0) ? tcfc_pkg::ST_BLOCK : tcfc_pkg::ST_FPS;
      end
      tcfc_pkg::ST_BLOCK: begin
        if (div_rsp.done) state_next = tcfc_pkg::ST_DROP_ADJ;
      end
      tcfc_pkg::ST_DROP_ADJ: begin
        state_next = (r_blk >= 16'(d_q)) ? tcfc_pkg::ST_MIN : tcfc_pkg::ST_FPS;
      end
      tcfc_pkg::ST_MIN: begin
        if (div_rsp.done) state_next = tcfc_pkg::ST_FPS;
      end
      tcfc_pkg::ST_FPS: begin
        if (div_rsp.done) state_next = tcfc_pkg::ST_SEC;
      end
      tcfc_pkg::ST_SEC: begin
        if (div_rsp.done) state_next = tcfc_pkg::ST_HRS;
      end
      tcfc_pkg::ST_HRS: begin
        if (div_rsp.done) state_next = tcfc_pkg::ST_FINISH;
      end
      tcfc_pkg::ST_FINISH: begin
        if (out_free) state_next = tcfc_pkg::ST_IDLE;
      end
      default: state_next = tcfc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider operands
  always_comb begin
    cmd_ready    = (state == tcfc_pkg::ST_IDLE);
    is_div_state = 1'b1;
    div_req      = '0;
    unique case (state)
      tcfc_pkg::ST_VAL: begin
        div_req.dividend = item_r.frame_value;
        div_req.divisor  = day_q;
        div_req.qbits    = tcfc_pkg::QbVal;
      end
      tcfc_pkg::ST_FMOD: begin
        div_req.dividend = 23'(item_r.in_frames);
        div_req.divisor  = 23'(fps_q);
        div_req.qbits    = tcfc_pkg::QbFmod;
      end
      tcfc_pkg::ST_BLOCK: begin
        div_req.dividend = count_r;
        div_req.divisor  = 23'(block_q);
        div_req.qbits    = tcfc_pkg::QbBlock;
      end
      tcfc_pkg::ST_MIN: begin
        div_req.dividend = 23'(rr_r);
        div_req.divisor  = 23'(minute_q);
        div_req.qbits    = tcfc_pkg::QbMin;
      end
      tcfc_pkg::ST_FPS: begin
        div_req.dividend = raw_r;
        div_req.divisor  = 23'(fps_q);
        div_req.qbits    = tcfc_pkg::QbFps;
      end
      tcfc_pkg::ST_SEC: begin
        div_req.dividend = 23'(secs_r);
        div_req.divisor  = 23'd60;
        div_req.qbits    = tcfc_pkg::QbSec;
      end
      tcfc_pkg::ST_HRS: begin
        div_req.dividend = 23'(mins_r);
        div_req.divisor  = 23'd60;
        div_req.qbits    = tcfc_pkg::QbHrs;
      end
      default: is_div_state = 1'b0;
    endcase
    div_req.start = is_div_state && !launched;
  end

  tcfc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Label normalization and label-to-count arithmetic
  always_comb begin
    s1     = {1'b0, item_r.in_seconds} + {7'b0, fcarry};
    scarry = s1 > 8'd59;
    m1_c   = {1'b0, item_r.in_minutes} + {7'b0, scarry};
    mcarry = m1_r > 8'd59;
    h1     = {1'b0, item_r.in_hours} + {7'b0, mcarry};

    tm         = 11'(h_n) * 11'd60 + 11'(m_n);
    tm10       = tcfc_pkg::div10_u11(tm);
    mq         = tcfc_pkg::div10_u11(11'(m_n));
    mrem_nz    = 11'(m_n) != 11'(mq) * 11'd10;
    // frame zero of second zero in a dropping minute moves past the skipped labels
    drop_label = (d_q != 3'd0) && (f_n == 6'd0) && (s_n == 6'd0) && mrem_nz;
    fadj_c     = drop_label ? 6'(d_q) : f_n;
    dsub_c     = 13'(d_q) * 13'(tm - 11'(tm10));
    secs_lbl_c = 17'(tm) * 17'd60 + 17'(s_n);
    t_c        = 23'(secs_lbl) * 23'(fps_q) + 23'(fadj) - 23'(dsub);

    // Offset add/subtract, wrapped once into the day
    sum    = {1'b0, t_r} + {1'b0, val_mod};
    sum_w  = sum - {1'b0, day_q};
    diff   = {1'b0, t_r} - {1'b0, val_mod};
    diff_w = diff + {1'b0, day_q};
    case (item_r.command)
      tcfc_pkg::CmdAddOffset: count_c = (sum >= {1'b0, day_q}) ? sum_w[22:0] : sum[22:0];
      tcfc_pkg::CmdSubOffset: count_c = diff[23] ? diff_w[22:0] : diff[22:0];
      default:                count_c = t_r;
    endcase
  end

  // Working registers, loaded by step
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      item_r <= cmd_data;
    end
    unique case (state)
      tcfc_pkg::ST_VAL: begin
        if (div_rsp.done) begin
          val_mod <= div_rsp.remainder;
          count_r <= div_rsp.remainder;
          raw_r   <= div_rsp.remainder;
        end
      end
      tcfc_pkg::ST_FMOD: begin
        if (div_rsp.done) begin
          f_n    <= div_rsp.remainder[5:0];
          fcarry <= |div_rsp.quotient[6:0];
        end
      end
      tcfc_pkg::ST_NORM_S: begin
        s_n  <= tcfc_pkg::mod60_u8(s1);
        m1_r <= m1_c;
      end
      tcfc_pkg::ST_NORM_MH: begin
        m_n <= tcfc_pkg::mod60_u8(m1_r);
        h_n <= tcfc_pkg::mod24_u8(h1);
      end
      tcfc_pkg::ST_LBL_A: begin
        secs_lbl <= secs_lbl_c;
        fadj     <= fadj_c;
        dsub     <= dsub_c;
      end
      tcfc_pkg::ST_LBL_B: t_r <= t_c;
      tcfc_pkg::ST_COMBINE: begin
        count_r <= count_c;
        raw_r   <= count_c;
      end
      tcfc_pkg::ST_BLOCK: begin
        if (div_rsp.done) begin
          q_blk <= div_rsp.quotient[8:0];
          r_blk <= div_rsp.remainder[15:0];
        end
      end
      // restore the labels skipped in earlier ten-minute blocks
      tcfc_pkg::ST_DROP_ADJ: begin
        raw_r <= count_r + 23'(d9_q) * 23'(q_blk);
        rr_r  <= r_blk - 16'(d_q);
      end
      // and those skipped in earlier minutes of this block
      tcfc_pkg::ST_MIN: begin
        if (div_rsp.done) begin
          raw_r <= raw_r + 23'(d_q) * 23'(div_rsp.quotient[4:0]);
        end
      end
      tcfc_pkg::ST_FPS: begin
        if (div_rsp.done) begin
          secs_r <= div_rsp.quotient[16:0];
          fr_o   <= div_rsp.remainder[5:0];
        end
      end
      tcfc_pkg::ST_SEC: begin
        if (div_rsp.done) begin
          mins_r <= div_rsp.quotient[10:0];
          sec_o  <= div_rsp.remainder[5:0];
        end
      end
      tcfc_pkg::ST_HRS: begin
        if (div_rsp.done) begin
          hr_o  <= div_rsp.quotient[4:0];
          min_o <= div_rsp.remainder[5:0];
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == tcfc_pkg::ST_FINISH && out_free) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tcfc_pkg::ST_FINISH && out_free) begin
      res_data <= '{out_hours:   hr_o,
                    out_minutes: min_o,
                    out_seconds: sec_o,
                    out_frames:  fr_o,
                    frame_count: count_r};
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> state != tcfc_pkg::ST_IDLE)
    else $error("accepted transaction did not start the sequencer");
  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> launched)
    else $error("divider result with no division outstanding");
  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    state == tcfc_pkg::ST_FINISH && res_valid && !res_ready |=>
      state == tcfc_pkg::ST_FINISH)
    else $error("sequencer left finish while result register was held");

endmodule
